>>> hw/rtl/pwmc_pkg.sv
// Shared types, constants and helper functions of the PWM period and duty calculator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pwmc_pkg;

  // Block configuration.
  localparam int NUM_TIMERS   = 4;
  localparam int COUNTER_BITS = 16;
  localparam int TIMER_W      = 2;
  localparam int CHAN_W       = 3;
  localparam int FREQ_W       = 32;
  localparam int DUTY_W       = 16;
  localparam int PS_W         = 3;
  localparam int BUS_KHZ_W    = 23;
  localparam int PREC_W       = 16;
  localparam int CLK_W        = 32;

  // Stream payload layout.
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  // Shared divider: dividend, quotient, divisor and step counter widths.
  localparam int DIV_W     = 33;
  localparam int DIVISOR_W = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [BUS_KHZ_W-1:0] BUS_KHZ_RST = BUS_KHZ_W'(60000);
  localparam logic [PREC_W-1:0]    PREC_RST    = PREC_W'(10000);
  localparam logic [DIV_W-1:0]     KHZ_TO_HZ   = DIV_W'(1000);
  localparam logic [4:0]           PS_MAX      = 5'h07;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX  = '1;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_DUTY = 2'd1,
    CMD_FREQ = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAN  = 3'd1,
    ST_ZERO_FREQ = 3'd2,
    ST_PS_OVER   = 3'd3,
    ST_DUTY_OVER = 3'd4,
    ST_UNSET     = 3'd5
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BUS_KHZ = 3'd0,
    REG_PREC_T0 = 3'd1,
    REG_PREC_T1 = 3'd2,
    REG_PREC_T2 = 3'd3,
    REG_PREC_T3 = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CLK,
    S_DIVQ,
    S_WAITQ,
    S_DIVM,
    S_WAITM,
    S_MULD,
    S_DIVC,
    S_WAITC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Number of significant bits of a value below 2^16.
  function automatic logic [4:0] bit_length(input logic [15:0] v);
    logic [4:0] len;
    len = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        len = 5'(i + 1);
      end
    end
    return len;
  endfunction

  // Clamp a quotient to the counter range.
  function automatic logic [COUNTER_BITS-1:0] sat_cnt(input logic [DIV_W-1:0] v);
    if (v[DIV_W-1:COUNTER_BITS] != '0) begin
      return CNT_MAX;
    end
    return v[COUNTER_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/pwmc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pwmc_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module pwmc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pwmc_pkg::div_req_t req,
  output pwmc_pkg::div_rsp_t rsp
);
  import pwmc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_STEPS;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with an exhausted step count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

>>> hw/rtl/pwm_period_duty_calculator_core.sv
// PWM period and duty calculator: top level with sequencer, register file and period store.
// Each division runs on the single shared bit-serial divider. One request is in work at a
// time; the next is taken the cycle after its result is registered, which waits while the
// output is full.
// Synchronous active-low reset restores the register defaults and marks every period unset.
`timescale 1ns / 1ps

module pwm_period_duty_calculator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, from bit 0: timer_sel(2), chan_sel(3), freq_hz(32), duty_num(16), zero fill
  input  logic [pwmc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: cmd(2)
  input  logic [pwmc_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata, from bit 0: prescale(3), modulo(16), compare(16), chan_out(3), zero fill
  output logic [pwmc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: status(3)
  output logic [pwmc_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwmc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pwmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pwmc_pkg::*;

  state_t state_r, state_nxt;

  cmd_t                    cmd_r;
  logic [TIMER_W-1:0]      t_r;
  logic [CHAN_W-1:0]       ch_r;
  logic [FREQ_W-1:0]       freq_r;
  logic [DUTY_W-1:0]       duty_r;

  logic [BUS_KHZ_W-1:0]    bus_khz_r;
  logic [PREC_W-1:0]       prec_r [4];
  logic [COUNTER_BITS-1:0] store_r [NUM_TIMERS];

  logic [CLK_W-1:0]        clk_r;
  logic [PS_W-1:0]         ps_r;
  logic [COUNTER_BITS-1:0] mod_r;
  logic [COUNTER_BITS-1:0] cmp_r;
  logic [DIV_W-1:0]        prod_r;
  status_t                 status_r;

  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [OUT_TUSER_W-1:0]  out_user_r;
  logic                    out_valid_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [PREC_W-1:0]       prec_sel;
  logic                    chan_bad;
  logic                    timer_bad;
  logic                    duty_over;
  status_t                 chk_status;
  logic [4:0]              q_len;
  logic [COUNTER_BITS-1:0] q_sat;
  logic                    out_free;
  logic                    store_we;
  logic [COUNTER_BITS-1:0] store_wdata;
  logic [DIV_W-1:0]        clk_prod;
  logic [DIV_W-1:0]        duty_prod;
  logic [COUNTER_BITS:0]   mod_plus1;
  logic [CLK_W-1:0]        clk_shifted;

  pwmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prec_sel  = prec_r[t_r];
  assign timer_bad = (int'(t_r) >= NUM_TIMERS);
  // Timers 1 and 2 only have channels 0 and 1.
  assign chan_bad  = ((t_r == 2'd1) || (t_r == 2'd2)) && (ch_r > 3'd1);
  assign duty_over = (duty_r > prec_sel);
  assign q_len     = bit_length(div_rsp.quotient[15:0]);
  assign q_sat     = sat_cnt(div_rsp.quotient);
  assign out_free  = !out_valid_r || out_tready;

  assign clk_prod    = {{(DIV_W-BUS_KHZ_W){1'b0}}, bus_khz_r} * KHZ_TO_HZ;
  assign mod_plus1   = {1'b0, mod_r} + 1'b1;
  assign duty_prod   = {{(DIV_W-DUTY_W){1'b0}}, duty_r} *
                       {{(DIV_W-COUNTER_BITS-1){1'b0}}, mod_plus1};
  assign clk_shifted = clk_r >> ps_r;

  // Checks done right after capture, in the order the command defines.
  always_comb begin
    chk_status = ST_OK;
    if (timer_bad) begin
      chk_status = ST_BAD_CHAN;
    end else begin
      case (cmd_r)
        CMD_INIT: begin
          if (chan_bad) begin
            chk_status = ST_BAD_CHAN;
          end else if (freq_r == '0) begin
            chk_status = ST_ZERO_FREQ;
          end
        end
        CMD_DUTY: begin
          if (chan_bad) begin
            chk_status = ST_BAD_CHAN;
          end else if (duty_over) begin
            chk_status = ST_DUTY_OVER;
          end else if (store_r[t_r] == '0) begin
            chk_status = ST_UNSET;
          end
        end
        CMD_FREQ: begin
          if (freq_r == '0) begin
            chk_status = ST_ZERO_FREQ;
          end
        end
        default: chk_status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = freq_r;
    store_we         = 1'b0;
    store_wdata      = mod_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cmd_r != CMD_INIT && cmd_r != CMD_DUTY && cmd_r != CMD_FREQ) begin
          state_nxt = S_IDLE;
        end else if (chk_status != ST_OK) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_DUTY) begin
          state_nxt = S_MULD;
        end else begin
          state_nxt = S_CLK;
        end
      end
      S_CLK: state_nxt = S_DIVQ;
      S_DIVQ: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(clk_r >> COUNTER_BITS);
        state_nxt        = S_WAITQ;
      end
      S_WAITQ: begin
        if (div_rsp.done) begin
          state_nxt = (q_len > PS_MAX) ? S_DONE : S_DIVM;
        end
      end
      S_DIVM: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, clk_shifted};
        state_nxt        = S_WAITM;
      end
      S_WAITM: begin
        if (div_rsp.done) begin
          if (cmd_r == CMD_FREQ) begin
            store_we    = 1'b1;
            store_wdata = q_sat;
            state_nxt   = S_DONE;
          end else if (duty_over) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MULD;
          end
        end
      end
      S_MULD: begin
        // A zero precision only gets here with a zero duty, whose compare is zero.
        if (prec_sel == '0) begin
          store_we  = (cmd_r == CMD_INIT);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIVC;
        end
      end
      S_DIVC: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = {{(DIVISOR_W-PREC_W){1'b0}}, prec_sel};
        state_nxt        = S_WAITC;
      end
      S_WAITC: begin
        if (div_rsp.done) begin
          store_we  = (cmd_r == CMD_INIT);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Request capture and datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_r  <= cmd_t'(in_tuser[1:0]);
          t_r    <= in_tdata[1:0];
          ch_r   <= in_tdata[4:2];
          freq_r <= in_tdata[36:5];
          duty_r <= in_tdata[52:37];
        end
      end
      S_CHECK: begin
        ps_r     <= '0;
        cmp_r    <= '0;
        mod_r    <= (cmd_r == CMD_DUTY) ? store_r[t_r] : '0;
        status_r <= chk_status;
      end
      S_CLK: clk_r <= clk_prod[CLK_W-1:0];
      S_WAITQ: begin
        if (div_rsp.done) begin
          ps_r <= q_len[PS_W-1:0];
          if (q_len > PS_MAX) begin
            status_r <= ST_PS_OVER;
          end
        end
      end
      S_WAITM: begin
        if (div_rsp.done) begin
          mod_r <= q_sat;
          if (cmd_r == CMD_INIT && duty_over) begin
            status_r <= ST_DUTY_OVER;
          end
        end
      end
      S_MULD: prod_r <= duty_prod;
      S_WAITC: begin
        if (div_rsp.done) begin
          cmp_r <= q_sat;
        end
      end
      default: ;
    endcase
  end

  // Period store and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_khz_r <= BUS_KHZ_RST;
      for (int i = 0; i < 4; i++) begin
        prec_r[i] <= PREC_RST;
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (store_we) begin
        store_r[t_r] <= store_wdata;
      end
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_addr))
          REG_BUS_KHZ: bus_khz_r <= cfg_data[BUS_KHZ_W-1:0];
          REG_PREC_T0: prec_r[0] <= cfg_data[PREC_W-1:0];
          REG_PREC_T1: prec_r[1] <= cfg_data[PREC_W-1:0];
          REG_PREC_T2: prec_r[2] <= cfg_data[PREC_W-1:0];
          REG_PREC_T3: prec_r[3] <= cfg_data[PREC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output register; a failed request reports zero prescale, modulo and compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
      out_user_r  <= status_r;
      if (status_r == ST_OK) begin
        out_data_r <= {2'b00, ch_r, cmp_r, mod_r, ps_r};
      end else begin
        out_data_r <= {2'b00, ch_r, {(2*COUNTER_BITS+PS_W){1'b0}}};
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted request did not enter the check step");

  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |-> (status_r == ST_OK))
    else $error("period store written for a failed request");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata[34:0] == '0))
    else $error("failed result carries nonzero settings");

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> div_rsp.busy)
    else $error("divider request not taken");

endmodule
